[rtl/vess_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vess_pkg;

  // Position sample width and the width of one difference between samples
  localparam int SAMPLE_BITS = 24;
  localparam int DIFF_W      = SAMPLE_BITS + 1;

  // Result and gain widths, Q16 gain
  localparam int VEL_W     = 32;
  localparam int GAIN_W    = 32;
  localparam int FRAC_BITS = 16;

  // Configuration register widths and reset values
  localparam int WLEN_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [WLEN_W-1:0] WINDOW_LEN_RST = 5'd1;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 32'd65536;

  // Default depth of the difference history
  localparam int MAX_WINDOW_DEF = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_RATE_GAIN  = 2'd1
  } cfg_reg_t;

  // Input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] pos_x;
    logic signed [SAMPLE_BITS-1:0] pos_y;
    logic signed [SAMPLE_BITS-1:0] pos_z;
  } pos_in_t;

  // Output transaction payload
  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic                    first_sample;
  } vel_out_t;

  // One stored difference, all three axes
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } diff_t;

  // Control shared by every cell of the history line
  typedef struct packed {
    logic fill;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/vess_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module vess_cell (
  input  wire logic                clk,
  input  wire vess_pkg::cell_ctrl_t ctrl,
  input  wire vess_pkg::diff_t     fill_data,
  input  wire vess_pkg::diff_t     chain_in,
  output vess_pkg::diff_t          q
);

  // Load the new difference on a window fill, else take the neighbor's on a shift
  always_ff @(posedge clk) begin
    if (ctrl.fill) begin
      q <= fill_data;
    end else if (ctrl.shift) begin
      q <= chain_in;
    end
  end

endmodule

`default_nettype wire

[rtl/vess_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module vess_scale #(
  parameter int SUM_W = 29
) (
  input  wire logic                             clk,
  input  wire logic                             mul_en,
  input  wire logic                             out_en,
  input  wire logic signed [SUM_W-1:0]          sum,
  input  wire logic [vess_pkg::GAIN_W-1:0]      gain,
  output logic signed [vess_pkg::VEL_W-1:0]     vel
);

  localparam int PROD_W = SUM_W + vess_pkg::GAIN_W + 1;
  localparam int VEL_W  = vess_pkg::VEL_W;

  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  shifted;
  logic [PROD_W-VEL_W:0]     hi;
  logic signed [VEL_W-1:0]   vel_next;

  // Multiply the window sum by the unsigned gain
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(sum) * PROD_W'($signed({1'b0, gain}));
    end
  end

  // Drop the fraction with a floor shift and clamp to the signed result range
  always_comb begin
    shifted = prod >>> vess_pkg::FRAC_BITS;
    hi      = shifted[PROD_W-1:VEL_W-1];
    if ((&hi) || !(|hi)) begin
      vel_next = shifted[VEL_W-1:0];
    end else if (shifted[PROD_W-1]) begin
      vel_next = {1'b1, {(VEL_W-1){1'b0}}};
    end else begin
      vel_next = {1'b0, {(VEL_W-1){1'b1}}};
    end
  end

  // Hold the result for the output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      vel <= vel_next;
    end
  end

endmodule

`default_nettype wire

[rtl/velocity_estimator_smoothed_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Smoothed three-axis velocity estimator.
// Input channel: in_valid / in_stall carry one position sample (x, y, z) per
// transaction. Output channel: out_valid / out_stall carry one velocity
// transaction per accepted sample, in order.
// Configuration: wr_en / wr_index / wr_data write window_len (index 0) or
// rate_gain (index 1); other indexes are ignored. Write only while idle.
// An accepted sample passes the running sum, gain product and output register
// in turn; one sample is taken every cycle unless a stall backs up, since the
// running sum and the history line of difference cells update in the cycle of
// acceptance and the 29 x 32 gain multiply has a stage of its own.
// The first sample after reset yields zero velocity with first_sample set;
// the second fills the window with its difference; later samples shift the
// cell line and update the running sum with the oldest difference removed.
// Reset clears the position and sums; window_len = 1, rate_gain = 1.0 (Q16).
// A stall from the receiver holds the output register and backs up through
// the three stages to in_stall in the same cycle; nothing is dropped.
module velocity_estimator_smoothed_unit #(
  parameter int MAX_WINDOW = vess_pkg::MAX_WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire vess_pkg::pos_in_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output vess_pkg::vel_out_t                     out_data,
  input  wire logic                              wr_en,
  input  wire logic [vess_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire logic [vess_pkg::GAIN_W-1:0]       wr_data
);

  localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int DIFF_W = vess_pkg::DIFF_W;
  localparam int SB     = vess_pkg::SAMPLE_BITS;
  localparam int SUM_W  = DIFF_W + $clog2(MAX_WINDOW);
  localparam int PF_W   = DIFF_W + WIN_W + 1;

  // Configuration registers
  logic [vess_pkg::WLEN_W-1:0] window_len;
  logic [vess_pkg::GAIN_W-1:0] rate_gain;

  // History state
  vess_pkg::pos_in_t        prev_pos;
  logic                     have_position;
  logic                     have_window;
  logic [IDX_W-1:0]         win_last;
  logic [IDX_W-1:0]         win_last_next;
  logic signed [SUM_W-1:0]  diff_sum      [3];
  logic signed [SUM_W-1:0]  diff_sum_next [3];

  // Pipeline control
  logic s1_valid, s1_first;
  logic s2_valid, s2_first;
  logic out_first;
  logic en1, en2, en_out;
  logic acc, fill, shift;

  // Datapath
  logic signed [SB-1:0]     pos  [3];
  logic signed [SB-1:0]     prv  [3];
  logic signed [DIFF_W-1:0] d    [3];
  logic signed [DIFF_W-1:0] tapv [3];
  logic signed [PF_W-1:0]   pfill [3];
  logic [WIN_W-1:0]         eff;
  vess_pkg::diff_t          d_pack;
  vess_pkg::diff_t          tap;
  vess_pkg::diff_t          cell_q [MAX_WINDOW];
  vess_pkg::cell_ctrl_t     cell_ctrl;
  logic signed [vess_pkg::VEL_W-1:0] vel [3];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= vess_pkg::WINDOW_LEN_RST;
      rate_gain  <= vess_pkg::RATE_GAIN_RST;
    end else if (wr_en) begin
      case (vess_pkg::cfg_reg_t'(wr_index))
        vess_pkg::CFG_WINDOW_LEN: window_len <= wr_data[vess_pkg::WLEN_W-1:0];
        vess_pkg::CFG_RATE_GAIN:  rate_gain  <= wr_data;
        default: ;
      endcase
    end
  end

  // Advance each stage when the one after it can take its transaction
  always_comb begin
    en_out   = !out_valid || !out_stall;
    en2      = !s2_valid || en_out;
    en1      = !s1_valid || en2;
    in_stall = !en1;
    acc      = in_valid && en1;
    fill     = acc && have_position && !have_window;
    shift    = acc && have_window;
  end

  // Effective window length, zero taken as one, clamped to the line depth
  always_comb begin
    if (int'(window_len) > MAX_WINDOW) begin
      eff = WIN_W'(MAX_WINDOW);
    end else begin
      eff = WIN_W'(window_len);
    end
    if (eff == '0) begin
      eff = WIN_W'(1);
    end
    win_last_next = IDX_W'(eff - WIN_W'(1));
  end

  // Form differences and the next running sums
  always_comb begin
    pos[0] = in_data.pos_x;
    pos[1] = in_data.pos_y;
    pos[2] = in_data.pos_z;
    prv[0] = prev_pos.pos_x;
    prv[1] = prev_pos.pos_y;
    prv[2] = prev_pos.pos_z;
    tap     = cell_q[win_last];
    tapv[0] = tap.dx;
    tapv[1] = tap.dy;
    tapv[2] = tap.dz;
    for (int a = 0; a < 3; a++) begin
      d[a] = $signed({pos[a][SB-1], pos[a]}) - $signed({prv[a][SB-1], prv[a]});
      pfill[a] = PF_W'(d[a]) * PF_W'($signed({1'b0, eff}));
      if (fill) begin
        diff_sum_next[a] = SUM_W'(pfill[a]);
      end else begin
        diff_sum_next[a] = diff_sum[a] - SUM_W'(tapv[a]) + SUM_W'(d[a]);
      end
    end
    d_pack.dx = d[0];
    d_pack.dy = d[1];
    d_pack.dz = d[2];
    cell_ctrl.fill  = fill;
    cell_ctrl.shift = shift;
  end

  // Update history state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos      <= '0;
      have_position <= 1'b0;
      have_window   <= 1'b0;
      win_last      <= '0;
      for (int a = 0; a < 3; a++) begin
        diff_sum[a] <= '0;
      end
    end else if (acc) begin
      prev_pos      <= in_data;
      have_position <= 1'b1;
      if (fill) begin
        have_window <= 1'b1;
        win_last    <= win_last_next;
      end
      if (fill || shift) begin
        for (int a = 0; a < 3; a++) begin
          diff_sum[a] <= diff_sum_next[a];
        end
      end
    end
  end

  // Line of difference cells, newest at cell zero
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      vess_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .fill_data (d_pack),
        .chain_in  (d_pack),
        .q         (cell_q[i])
      );
    end else begin : g_body
      vess_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .fill_data (d_pack),
        .chain_in  (cell_q[i-1]),
        .q         (cell_q[i])
      );
    end
  end

  // Pipeline valid and first-sample flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_first  <= 1'b0;
      s2_valid  <= 1'b0;
      s2_first  <= 1'b0;
      out_valid <= 1'b0;
      out_first <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= acc;
        s1_first <= !have_position;
      end
      if (en2) begin
        s2_valid <= s1_valid;
        s2_first <= s1_first;
      end
      if (en_out) begin
        out_valid <= s2_valid;
        out_first <= s2_first;
      end
    end
  end

  // Gain multiply and saturation per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    vess_scale #(
      .SUM_W (SUM_W)
    ) u_scale (
      .clk    (clk),
      .mul_en (en2),
      .out_en (en_out),
      .sum    (diff_sum[a]),
      .gain   (rate_gain),
      .vel    (vel[a])
    );
  end

  // Drive the output payload
  always_comb begin
    out_data.vel_x        = vel[0];
    out_data.vel_y        = vel[1];
    out_data.vel_z        = vel[2];
    out_data.first_sample = out_first;
  end

`ifndef SYNTHESIS
  // The window is only filled after a position has been stored
  assert property (@(posedge clk) disable iff (rst) have_window |-> have_position)
    else $error("window filled without a stored position");

  // The first transaction after reset enters the pipe marked as first
  assert property (@(posedge clk) disable iff (rst)
    acc && !have_position |=> have_position && s1_valid && s1_first)
    else $error("first sample not marked");

  // A first-sample result carries zero velocity
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.first_sample |->
      out_data.vel_x == '0 && out_data.vel_y == '0 && out_data.vel_z == '0)
    else $error("first sample result not zero");

  // Input is held off only when every stage is occupied
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s2_valid && out_valid && out_stall)
    else $error("input stalled with room in the pipe");

  // The latched window length holds once the window is filled
  assert property (@(posedge clk) disable iff (rst) have_window |=> $stable(win_last))
    else $error("window length changed after fill");
`endif

endmodule

`default_nettype wire

[sim/velocity_estimator_smoothed_unit_checker.sv]
`timescale 1ns / 1ps

// Watch both channels and the register port of the velocity estimator,
// predict every velocity transaction and compare it with what comes out.
module velocity_estimator_smoothed_unit_checker #(
  parameter int MAX_WINDOW = vess_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  vess_pkg::pos_in_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  vess_pkg::vel_out_t             out_data,
  input  logic                           wr_en,
  input  logic [vess_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [vess_pkg::GAIN_W-1:0]    wr_data,
  output int                             errors,
  output int                             pending
);

  localparam int SAMPLE_BITS = vess_pkg::SAMPLE_BITS;
  localparam int DIFF_W      = vess_pkg::DIFF_W;
  localparam int VEL_W       = vess_pkg::VEL_W;
  localparam int WLEN_W      = vess_pkg::WLEN_W;
  localparam int SUM_W       = DIFF_W + $clog2(MAX_WINDOW);
  localparam int DUE_DEPTH   = 64;
  localparam int DUE_PTR_W   = 6;
  localparam longint VEL_MAX = (longint'(1) <<< (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -(longint'(1) <<< (VEL_W - 1));

  // Shadow registers and estimator state
  logic [WLEN_W-1:0]             win_reg  = vess_pkg::WINDOW_LEN_RST;
  logic [vess_pkg::GAIN_W-1:0]   gain_reg = vess_pkg::RATE_GAIN_RST;
  logic signed [SAMPLE_BITS-1:0] last_pos [3];
  logic signed [DIFF_W-1:0]      hist [MAX_WINDOW][3];
  logic signed [SUM_W-1:0]       axis_sum [3];
  int unsigned                   slot;
  int unsigned                   span;
  logic                          seen_first;
  logic                          window_full;

  // Velocities still owed by the block, oldest first, in a circular buffer
  vess_pkg::vel_out_t   vel_due [DUE_DEPTH];
  logic [DUE_PTR_W-1:0] due_rd;
  logic [DUE_PTR_W-1:0] due_wr;
  int                   due_cnt;

  // Apply the Q16 gain with a floor shift and clamp to the result width
  function automatic logic signed [VEL_W-1:0] scale_velocity(
    input logic signed [SUM_W-1:0] s
  );
    longint prod;
    prod = longint'(s) * longint'(gain_reg);
    prod = prod >>> vess_pkg::FRAC_BITS;
    if (prod > VEL_MAX) return VEL_W'(VEL_MAX);
    if (prod < VEL_MIN) return VEL_W'(VEL_MIN);
    return VEL_W'(prod);
  endfunction

  // Advance the estimator by one position sample and queue its velocity
  task automatic predict_velocity(input vess_pkg::pos_in_t s);
    logic signed [SAMPLE_BITS-1:0] p [3];
    logic signed [DIFF_W-1:0] d;
    vess_pkg::vel_out_t v;
    int unsigned w;
    p[0] = s.pos_x;
    p[1] = s.pos_y;
    p[2] = s.pos_z;
    v = '0;
    if (!seen_first) begin
      // First sample: store only, report zero velocity
      for (int a = 0; a < 3; a++) last_pos[a] = p[a];
      seen_first = 1'b1;
      v.first_sample = 1'b1;
    end else begin
      if (!window_full) begin
        // Latch the window length and fill every slot in use
        w = win_reg;
        if (w == 0) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        span = w;
        for (int a = 0; a < 3; a++) begin
          d = DIFF_W'(p[a]) - DIFF_W'(last_pos[a]);
          axis_sum[a] = '0;
          for (int k = 0; k < span; k++) begin
            hist[k][a] = d;
            axis_sum[a] = axis_sum[a] + SUM_W'(d);
          end
        end
        slot = 0;
        window_full = 1'b1;
      end else begin
        // Replace the oldest difference and keep the running sum
        for (int a = 0; a < 3; a++) begin
          d = DIFF_W'(p[a]) - DIFF_W'(last_pos[a]);
          axis_sum[a] = axis_sum[a] - SUM_W'(hist[slot][a]) + SUM_W'(d);
          hist[slot][a] = d;
        end
        slot = slot + 1;
        if (slot >= span) slot = 0;
      end
      for (int a = 0; a < 3; a++) last_pos[a] = p[a];
      v.vel_x = scale_velocity(axis_sum[0]);
      v.vel_y = scale_velocity(axis_sum[1]);
      v.vel_z = scale_velocity(axis_sum[2]);
    end
    if (due_cnt >= DUE_DEPTH) begin
      errors++;
      $display("%0t: more velocities owed than the checker can hold", $time);
    end else begin
      vel_due[due_wr] = v;
      due_wr = due_wr + 1'b1;
      due_cnt++;
    end
  endtask

  always @(posedge clk) begin
    vess_pkg::vel_out_t want;
    if (rst) begin
      win_reg     = vess_pkg::WINDOW_LEN_RST;
      gain_reg    = vess_pkg::RATE_GAIN_RST;
      seen_first  = 1'b0;
      window_full = 1'b0;
      slot        = 0;
      span        = 1;
      for (int a = 0; a < 3; a++) begin
        last_pos[a] = '0;
        axis_sum[a] = '0;
      end
      due_rd  = '0;
      due_wr  = '0;
      due_cnt = 0;
      errors  = 0;
    end else begin
      // Track register writes; unknown indexes change nothing
      if (wr_en) begin
        case (wr_index)
          vess_pkg::CFG_WINDOW_LEN: win_reg = wr_data[WLEN_W-1:0];
          vess_pkg::CFG_RATE_GAIN:  gain_reg = wr_data;
          default: ;
        endcase
      end

      // Compare each output transaction with the oldest prediction
      if (out_valid && !out_stall) begin
        if (due_cnt == 0) begin
          errors++;
          $display("%0t: velocity with none expected: x=%0d y=%0d z=%0d first=%0b",
                   $time, out_data.vel_x, out_data.vel_y, out_data.vel_z,
                   out_data.first_sample);
        end else begin
          want = vel_due[due_rd];
          due_rd = due_rd + 1'b1;
          due_cnt--;
          if (out_data.vel_x !== want.vel_x || out_data.vel_y !== want.vel_y ||
              out_data.vel_z !== want.vel_z ||
              out_data.first_sample !== want.first_sample) begin
            errors++;
            $display({"%0t: velocity mismatch: expected x=%0d y=%0d z=%0d first=%0b,",
                      " got x=%0d y=%0d z=%0d first=%0b"},
                     $time, want.vel_x, want.vel_y, want.vel_z, want.first_sample,
                     out_data.vel_x, out_data.vel_y, out_data.vel_z,
                     out_data.first_sample);
          end
        end
      end

      // Predict each accepted input transaction
      if (in_valid && !in_stall) predict_velocity(in_data);
    end
    pending = due_cnt;
  end

endmodule

[sim/velocity_estimator_smoothed_unit_test.sv]
`timescale 1ns / 1ps

module velocity_estimator_smoothed_unit_test;

  localparam int SAMPLE_BITS = vess_pkg::SAMPLE_BITS;
  localparam int CFG_IDX_W   = vess_pkg::CFG_IDX_W;
  localparam int GAIN_W      = vess_pkg::GAIN_W;
  localparam int LATENCY     = 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 267;
  localparam int HOLD_CYCLES = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] POS_MIN = 24'sh800000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  vess_pkg::pos_in_t    in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vess_pkg::vel_out_t   out_data;
  logic                 wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index  = '0;
  logic [GAIN_W-1:0]    wr_data   = '0;

  int                errors;
  int                pending;
  int                send_idle_pct = 29;
  int                recv_idle_pct = 71;
  int                hold_req      = 0;
  int unsigned       cycles        = 0;
  vess_pkg::pos_in_t walk          = '0;

  velocity_estimator_smoothed_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  velocity_estimator_smoothed_unit_checker vel_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive the receiver stall: random idling, or a long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_stall <= 1'b0;
      end else if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Write one register, then drop the enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one sample after a random gap and hold it until accepted
  task automatic send_sample(input vess_pkg::pos_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_xyz(input logic signed [SAMPLE_BITS-1:0] x,
                          input logic signed [SAMPLE_BITS-1:0] y,
                          input logic signed [SAMPLE_BITS-1:0] z);
    vess_pkg::pos_in_t s;
    s.pos_x = x;
    s.pos_y = y;
    s.pos_z = z;
    walk = s;
    send_sample(s);
  endtask

  // Stop offering and wait until every velocity has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // Step of random size, from zero or minus one up to the full sample range
  function automatic logic signed [SAMPLE_BITS-1:0] random_step();
    int k;
    k = $urandom_range(SAMPLE_BITS - 1);
    return SAMPLE_BITS'(int'($urandom) >>> (31 - k));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] corner_pos();
    case ($urandom_range(4))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'(1);
    endcase
  endfunction

  // Mostly a smooth trajectory, with jumps to random and extreme positions
  function automatic vess_pkg::pos_in_t random_sample();
    vess_pkg::pos_in_t s;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      s.pos_x = walk.pos_x + random_step();
      s.pos_y = walk.pos_y + random_step();
      s.pos_z = walk.pos_z + random_step();
    end else if (pick < 85) begin
      s.pos_x = SAMPLE_BITS'($urandom);
      s.pos_y = SAMPLE_BITS'($urandom);
      s.pos_z = SAMPLE_BITS'($urandom);
    end else begin
      s.pos_x = corner_pos();
      s.pos_y = corner_pos();
      s.pos_z = corner_pos();
    end
    walk = s;
    return s;
  endfunction

  // Gain spread over its whole range on a log scale, plus the extremes
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0: return vess_pkg::RATE_GAIN_RST;
      1: return '1;
      2: return '0;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Ignored indexes, then the window length that the fill latches
    write_reg(CFG_SPARE_2, $urandom);
    write_reg(CFG_SPARE_3, $urandom);
    case ($urandom_range(5))
      0: ;  // keep the reset length
      1: write_reg(vess_pkg::CFG_WINDOW_LEN, 0);
      2: write_reg(vess_pkg::CFG_WINDOW_LEN, vess_pkg::MAX_WINDOW_DEF);
      3: write_reg(vess_pkg::CFG_WINDOW_LEN, 31);
      4: write_reg(vess_pkg::CFG_WINDOW_LEN, vess_pkg::MAX_WINDOW_DEF + 1);
      default: write_reg(vess_pkg::CFG_WINDOW_LEN,
                         $urandom_range(2, vess_pkg::MAX_WINDOW_DEF - 1));
    endcase

    // First sample, fill with the widest differences, then full swings
    send_xyz(POS_MAX, POS_MIN, '0);
    send_xyz(POS_MIN, POS_MAX, '0);
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_xyz(POS_MAX, POS_MIN, POS_MAX);
      else send_xyz(POS_MIN, POS_MAX, POS_MIN);
    end
    send_xyz('0, '0, '0);
    send_xyz('0, '0, '0);
    send_xyz(SAMPLE_BITS'(1), '1, '0);

    // Largest gain saturates both ways; window writes after the fill are ignored
    wait_idle();
    write_reg(vess_pkg::CFG_RATE_GAIN, '1);
    write_reg(vess_pkg::CFG_WINDOW_LEN, 0);
    for (int i = 0; i < 4; i++) begin
      if (i % 2 == 0) send_xyz(POS_MAX, POS_MIN, POS_MAX);
      else send_xyz(POS_MIN, POS_MAX, POS_MIN);
    end

    // Zero gain gives zero velocity
    wait_idle();
    write_reg(vess_pkg::CFG_RATE_GAIN, '0);
    write_reg(vess_pkg::CFG_WINDOW_LEN, 31);
    send_sample(random_sample());
    send_sample(random_sample());

    // Tiny gain: negative sums floor to minus one
    wait_idle();
    write_reg(vess_pkg::CFG_RATE_GAIN, 1);
    send_xyz(-24'sd5, 24'sd5, '0);
    send_xyz(-24'sd6, 24'sd6, '0);
    send_xyz(-24'sd7, 24'sd7, '0);

    // Random phases with different idling on the two sides
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_idle_pct = 29; recv_idle_pct = 71; end
        1: begin send_idle_pct = 71; recv_idle_pct = 29; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(vess_pkg::CFG_RATE_GAIN, pick_gain());
      write_reg(vess_pkg::CFG_WINDOW_LEN, $urandom);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && phase != 1) hold_req = HOLD_CYCLES;
        if (i == PHASE_ITEMS / 3 * 2 && phase != 0) begin
          wait_idle();
          write_reg(vess_pkg::CFG_RATE_GAIN, pick_gain());
        end
        send_sample(random_sample());
      end
    end

    wait_idle();
    repeat (LATENCY * 4) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/vess_pkg.sv
rtl/vess_cell.sv
rtl/vess_scale.sv
rtl/velocity_estimator_smoothed_unit.sv
sim/velocity_estimator_smoothed_unit_checker.sv
sim/velocity_estimator_smoothed_unit_test.sv
